FILE: rtl/dce_pkg.sv
package dce_pkg;

    // Default sine table resolution: top bits of the 16-bit angle that are used.
    localparam int ANGLE_BITS_DEF = 16;

    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 24;
    localparam int AXIS_W   = 25;
    localparam int SINE_W   = 31;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    // The Taylor series uses six Horner steps, one per divisor.
    localparam int          DIV_COUNT = 6;
    localparam logic [2:0]  DIV_LAST  = 3'(DIV_COUNT - 1);

    typedef struct packed {
        logic              we;
        logic [SINE_W-1:0] data;
    } rom_wr_t;

    function automatic logic [7:0] div_const(input logic [2:0] step);
        logic [7:0] k;
        case (step)
            3'd0:    k = 8'd156;
            3'd1:    k = 8'd110;
            3'd2:    k = 8'd72;
            3'd3:    k = 8'd42;
            3'd4:    k = 8'd20;
            3'd5:    k = 8'd6;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / k) for each divisor above.
    function automatic logic [31:0] div_recip(input logic [2:0] step);
        logic [31:0] m;
        case (step)
            3'd0:    m = 32'd27531841;
            3'd1:    m = 32'd39045157;
            3'd2:    m = 32'd59652323;
            3'd3:    m = 32'd102261126;
            3'd4:    m = 32'd214748364;
            3'd5:    m = 32'd715827882;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/dce_sine_gen.sv
module dce_sine_gen #(
    parameter int ANGLE_BITS = dce_pkg::ANGLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output dce_pkg::rom_wr_t         wr,
    output logic [ANGLE_BITS-2:0]    wr_addr,
    output logic                     done
);

    localparam int QS = ANGLE_BITS - 2;
    localparam int AW = ANGLE_BITS - 1;
    localparam logic [AW-1:0] QN = AW'(1) << QS;

    typedef enum logic [6:0] {
        G_X    = 7'b0000001,
        G_X2   = 7'b0000010,
        G_MUL  = 7'b0000100,
        G_DIV  = 7'b0001000,
        G_UPD  = 7'b0010000,
        G_FIN  = 7'b0100000,
        G_DONE = 7'b1000000
    } gen_state_t;

    gen_state_t  state_reg, state_next;
    logic [AW-1:0] p_reg;
    logic [2:0]  iter_reg;
    logic [30:0] x_reg;
    logic [31:0] x2_reg;
    logic [30:0] t_reg;
    logic [31:0] q_reg;
    logic [31:0] est_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] round30;
    logic [30:0] x_calc;
    logic [30:0] fin_calc;
    logic [7:0]  div_k;
    logic [31:0] div_m;
    logic [31:0] est_k;
    logic [31:0] fix;
    logic [31:0] quot;

    always_comb
    begin
        case (state_reg)
            G_X:
            begin
                mul_a = 32'(p_reg);
                mul_b = 32'(dce_pkg::HALF_PI_Q30);
            end
            G_X2:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            G_MUL:
            begin
                mul_a = x2_reg;
                mul_b = 32'(t_reg);
            end
            G_DIV:
            begin
                mul_a = q_reg;
                mul_b = div_m;
            end
            G_FIN:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(t_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign round30 = (prod + 64'(2**29)) >> 30;
    assign x_calc  = 31'((prod + 64'(2**(QS-1))) >> QS);
    assign fin_calc = (round30 > 64'(dce_pkg::ONE_Q30)) ? dce_pkg::ONE_Q30 : round30[30:0];

    // The scaled reciprocal gives the quotient or one less; one compare settles it.
    assign div_k = dce_pkg::div_const(iter_reg);
    assign div_m = dce_pkg::div_recip(iter_reg);
    assign est_k = est_reg * 32'(div_k);
    assign fix   = q_reg - est_k;
    assign quot  = est_reg + 32'(fix >= 32'(div_k));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            G_X:    state_next = G_X2;
            G_X2:   state_next = G_MUL;
            G_MUL:  state_next = G_DIV;
            G_DIV:  state_next = G_UPD;
            G_UPD:  state_next = (iter_reg == dce_pkg::DIV_LAST) ? G_FIN : G_MUL;
            G_FIN:  state_next = (p_reg == QN) ? G_DONE : G_X;
            G_DONE: state_next = G_DONE;
            default: state_next = G_X;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_X;
            p_reg     <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                G_X2:  iter_reg <= '0;
                G_UPD: iter_reg <= iter_reg + 3'd1;
                G_FIN:
                begin
                    if (p_reg != QN)
                    begin
                        p_reg <= p_reg + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_X:  x_reg <= x_calc;
            G_X2:
            begin
                x2_reg <= round30[31:0];
                t_reg  <= dce_pkg::ONE_Q30;
            end
            G_MUL: q_reg   <= 32'(prod >> 30);
            G_DIV: est_reg <= prod[63:32];
            G_UPD:
            begin
                t_reg <= (quot > 32'(dce_pkg::ONE_Q30)) ? 31'd0
                                                        : 31'(32'(dce_pkg::ONE_Q30) - quot);
            end
            default: ;
        endcase
    end

    assign wr.we   = (state_reg == G_FIN);
    assign wr.data = fin_calc;
    assign wr_addr = p_reg;
    assign done    = (state_reg == G_DONE);

endmodule

FILE: rtl/dce_lobe.sv
module dce_lobe #(
    parameter int ANGLE_BITS = dce_pkg::ANGLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  dce_pkg::rom_wr_t        wr,
    input  logic [ANGLE_BITS-2:0]   wr_addr,
    input  logic [23:0]             radius,
    input  logic [24:0]             axis,
    input  logic [15:0]             angle,
    output logic [24:0]             mag_x,
    output logic                    neg_x,
    output logic [24:0]             mag_y,
    output logic                    neg_y
);

    localparam int QS     = ANGLE_BITS - 2;
    localparam int AW     = ANGLE_BITS - 1;
    localparam int QDEPTH = 2**QS + 1;

    function automatic logic [AW-1:0] quarter_addr(input logic [ANGLE_BITS-1:0] idx);
        logic [AW-1:0] p;
        p = AW'(idx[QS-1:0]);
        if (idx[QS])
        begin
            return (AW'(1) << QS) - p;
        end
        return p;
    endfunction

    logic [30:0] rom_mem [QDEPTH];

    logic [ANGLE_BITS-1:0] idx_y, idx_x;
    logic [24:0] two_r;
    logic        m_pos;
    logic [24:0] tm_mag;

    logic [30:0] rd_x_reg, rd_y_reg;
    logic [24:0] tm_reg;
    logic        neg_x1_reg, neg_y1_reg;
    logic [55:0] prod_x_reg, prod_y_reg;
    logic        neg_x2_reg, neg_y2_reg;
    logic [24:0] mag_x_reg, mag_y_reg;
    logic        neg_x3_reg, neg_y3_reg;

    assign idx_y  = angle[15 -: ANGLE_BITS];
    assign idx_x  = idx_y + (ANGLE_BITS'(1) << QS);
    assign two_r  = {radius, 1'b0};
    assign m_pos  = axis >= two_r;
    // A short axis gives a negative half span; the lobes simply swap sides.
    assign tm_mag = m_pos ? axis - two_r : two_r - axis;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            rom_mem[wr_addr] <= wr.data;
        end
        if (en)
        begin
            rd_x_reg <= rom_mem[quarter_addr(idx_x)];
            rd_y_reg <= rom_mem[quarter_addr(idx_y)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_reg     <= tm_mag;
            neg_x1_reg <= idx_x[ANGLE_BITS-1] ^ !m_pos;
            neg_y1_reg <= idx_y[ANGLE_BITS-1] ^ !m_pos;

            prod_x_reg <= 56'(tm_reg) * 56'(rd_x_reg);
            prod_y_reg <= 56'(tm_reg) * 56'(rd_y_reg);
            neg_x2_reg <= neg_x1_reg;
            neg_y2_reg <= neg_y1_reg;

            // Rounding on the magnitude gives half away from zero.
            mag_x_reg  <= 25'((prod_x_reg + 56'(2**30)) >> 31);
            mag_y_reg  <= 25'((prod_y_reg + 56'(2**30)) >> 31);
            neg_x3_reg <= neg_x2_reg;
            neg_y3_reg <= neg_y2_reg;
        end
    end

    assign mag_x = mag_x_reg;
    assign neg_x = neg_x3_reg;
    assign mag_y = mag_y_reg;
    assign neg_y = neg_y3_reg;

endmodule

FILE: rtl/dce_sqrt.sv
module dce_sqrt #(
    parameter int SIDE_W = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       in_val,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [32:0]       out_rem,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STEPS = 32;

    logic [63:0]       rem_reg  [1:STEPS];
    logic [63:0]       res_reg  [1:STEPS];
    logic [SIDE_W-1:0] side_reg [1:STEPS];
    logic [STEPS:1]    vld_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic [63:0] BIT_C = 64'(1) << (62 - 2*i);
        logic [63:0]       rem_in, res_in, trial;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        if (i == 0)
        begin : g_first
            assign rem_in  = in_val;
            assign res_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i];
            assign res_in  = res_reg[i];
            assign side_in = side_reg[i];
            assign vld_in  = vld_reg[i];
        end

        assign trial = res_in + BIT_C;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[i+1] <= rem_in - trial;
                    res_reg[i+1] <= (res_in >> 1) + BIT_C;
                end
                else
                begin
                    rem_reg[i+1] <= rem_in;
                    res_reg[i+1] <= res_in >> 1;
                end
                side_reg[i+1] <= side_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_in;
            end
        end
    end

    assign out_vld  = vld_reg[STEPS];
    assign out_rem  = rem_reg[STEPS][32:0];
    assign out_root = res_reg[STEPS][31:0];
    assign out_side = side_reg[STEPS];

endmodule

FILE: rtl/dumbbell_cell_edge_distance_top.sv
// Channel  Direction  Handshake             Payload
// in       into       in_valid / in_stall   a_pos_x .. a_angle, b_pos_x .. b_angle
// out      out of     out_valid / out_stall edge_gap, gap_saturated
//
// One pair is taken per cycle while in_stall is low; the pipeline holds a square root
// that is itself pipelined, one stage per root bit.
// After reset the sine table is built one entry at a time, for 2^(ANGLE_BITS-2)+1 entries;
// in_stall stays high meanwhile.
// A stalled result parks in a skid register; the pipeline freezes only once that is full.
module dumbbell_cell_edge_distance_top #(
    parameter int ANGLE_BITS = dce_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] a_pos_x,
    input  logic signed [31:0] a_pos_y,
    input  logic [23:0]        a_lobe_radius,
    input  logic [24:0]        a_axis_len,
    input  logic [15:0]        a_angle,
    input  logic signed [31:0] b_pos_x,
    input  logic signed [31:0] b_pos_y,
    input  logic [23:0]        b_lobe_radius,
    input  logic [24:0]        b_axis_len,
    input  logic [15:0]        b_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] edge_gap,
    output logic               gap_saturated
);

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } pos_t;

    logic en, fill_done, take;
    dce_pkg::rom_wr_t rom_wr;
    logic [ANGLE_BITS-2:0] rom_addr;

    logic [24:0] a_mag_x, a_mag_y, b_mag_x, b_mag_y;
    logic        a_neg_x, a_neg_y, b_neg_x, b_neg_y;

    logic [10:1] vld_reg;
    pos_t        pos_reg  [1:3];
    logic [24:0] rsum_reg [1:10];

    logic signed [32:0] alx_reg [2], aly_reg [2], blx_reg [2], bly_reg [2];
    logic signed [33:0] dx_reg [4], dy_reg [4];
    logic [31:0]        ux_reg [4], uy_reg [4];
    logic [3:0]         big6_reg, big7_reg;
    logic [63:0]        sx_reg [4], sy_reg [4];
    logic [63:0]        d_reg [4];
    logic [63:0]        m_reg [2];
    logic [63:0]        best_reg;

    logic        sq_vld;
    logic [32:0] sq_rem;
    logic [31:0] sq_root;
    logic [24:0] sq_rsum;

    logic        vld_r_reg;
    logic [32:0] root_reg;
    logic [24:0] rsum_r_reg;

    logic signed [34:0] gap;
    logic               sat;
    logic signed [31:0] gap_clip;

    logic               out_vld_reg, skid_vld_reg, out_take;
    logic signed [31:0] out_gap_reg, skid_gap_reg;
    logic               out_sat_reg, skid_sat_reg;

    logic signed [32:0] aox, aoy, box, boy;

    assign en       = !skid_vld_reg;
    assign in_stall = !en || !fill_done;
    assign take     = in_valid && !in_stall;

    dce_sine_gen #(.ANGLE_BITS(ANGLE_BITS)) u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rom_wr),
        .wr_addr (rom_addr),
        .done    (fill_done)
    );

    dce_lobe #(.ANGLE_BITS(ANGLE_BITS)) u_lobe_a (
        .clk     (clk),
        .en      (en),
        .wr      (rom_wr),
        .wr_addr (rom_addr),
        .radius  (a_lobe_radius),
        .axis    (a_axis_len),
        .angle   (a_angle),
        .mag_x   (a_mag_x),
        .neg_x   (a_neg_x),
        .mag_y   (a_mag_y),
        .neg_y   (a_neg_y)
    );

    dce_lobe #(.ANGLE_BITS(ANGLE_BITS)) u_lobe_b (
        .clk     (clk),
        .en      (en),
        .wr      (rom_wr),
        .wr_addr (rom_addr),
        .radius  (b_lobe_radius),
        .axis    (b_axis_len),
        .angle   (b_angle),
        .mag_x   (b_mag_x),
        .neg_x   (b_neg_x),
        .mag_y   (b_mag_y),
        .neg_y   (b_neg_y)
    );

    always_comb
    begin
        aox = a_neg_x ? -$signed({8'd0, a_mag_x}) : $signed({8'd0, a_mag_x});
        aoy = a_neg_y ? -$signed({8'd0, a_mag_y}) : $signed({8'd0, a_mag_y});
        box = b_neg_x ? -$signed({8'd0, b_mag_x}) : $signed({8'd0, b_mag_x});
        boy = b_neg_y ? -$signed({8'd0, b_mag_y}) : $signed({8'd0, b_mag_y});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[9:1], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[1]  <= '{a_pos_x, a_pos_y, b_pos_x, b_pos_y};
            pos_reg[2]  <= pos_reg[1];
            pos_reg[3]  <= pos_reg[2];
            rsum_reg[1] <= 25'(a_lobe_radius) + 25'(b_lobe_radius);
            for (int s = 2; s <= 10; s++)
            begin
                rsum_reg[s] <= rsum_reg[s-1];
            end

            alx_reg[0] <= 33'(pos_reg[3].ax) + aox;
            alx_reg[1] <= 33'(pos_reg[3].ax) - aox;
            aly_reg[0] <= 33'(pos_reg[3].ay) + aoy;
            aly_reg[1] <= 33'(pos_reg[3].ay) - aoy;
            blx_reg[0] <= 33'(pos_reg[3].bx) + box;
            blx_reg[1] <= 33'(pos_reg[3].bx) - box;
            bly_reg[0] <= 33'(pos_reg[3].by) + boy;
            bly_reg[1] <= 33'(pos_reg[3].by) - boy;

            for (int k = 0; k < 4; k++)
            begin
                dx_reg[k] <= 34'(alx_reg[k/2]) - 34'(blx_reg[k%2]);
                dy_reg[k] <= 34'(aly_reg[k/2]) - 34'(bly_reg[k%2]);
            end

            // A difference of 2^32 or more marks the pair as out of range.
            for (int k = 0; k < 4; k++)
            begin
                ux_reg[k]   <= dx_reg[k][33] ? 32'(-dx_reg[k]) : dx_reg[k][31:0];
                uy_reg[k]   <= dy_reg[k][33] ? 32'(-dy_reg[k]) : dy_reg[k][31:0];
                big6_reg[k] <= (dx_reg[k] >= 34'sh100000000) || (dx_reg[k] <= -34'sh100000000)
                            || (dy_reg[k] >= 34'sh100000000) || (dy_reg[k] <= -34'sh100000000);
            end

            for (int k = 0; k < 4; k++)
            begin
                sx_reg[k]   <= 64'(ux_reg[k]) * 64'(ux_reg[k]);
                sy_reg[k]   <= 64'(uy_reg[k]) * 64'(uy_reg[k]);
                big7_reg[k] <= big6_reg[k];
            end

            for (int k = 0; k < 4; k++)
            begin
                d_reg[k] <= (big7_reg[k] || (65'(sx_reg[k]) + 65'(sy_reg[k]) > 65'(64'hFFFF_FFFF_FFFF_FFFF)))
                          ? '1 : sx_reg[k] + sy_reg[k];
            end

            m_reg[0] <= (d_reg[1] < d_reg[0]) ? d_reg[1] : d_reg[0];
            m_reg[1] <= (d_reg[3] < d_reg[2]) ? d_reg[3] : d_reg[2];
            best_reg <= (m_reg[1] < m_reg[0]) ? m_reg[1] : m_reg[0];
        end
    end

    dce_sqrt #(.SIDE_W(25)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_reg[10]),
        .in_val   (best_reg),
        .in_side  (rsum_reg[10]),
        .out_vld  (sq_vld),
        .out_rem  (sq_rem),
        .out_root (sq_root),
        .out_side (sq_rsum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_r_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_r_reg <= sq_vld;
        end
    end

    // The remainder is value minus root squared; above the root means round up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg   <= {1'b0, sq_root} + 33'(sq_rem > {1'b0, sq_root});
            rsum_r_reg <= sq_rsum;
        end
    end

    always_comb
    begin
        gap = $signed({2'b00, root_reg}) - $signed({10'd0, rsum_r_reg});
        sat = 1'b0;
        gap_clip = gap[31:0];
        if (gap > 35'sd2147483647)
        begin
            gap_clip = 32'sh7FFFFFFF;
            sat      = 1'b1;
        end
        else if (gap < -35'sd2147483648)
        begin
            gap_clip = 32'sh80000000;
            sat      = 1'b1;
        end
    end

    assign out_take = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (vld_r_reg)
        begin
            if (out_vld_reg && !out_take)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_take)
            begin
                out_gap_reg <= skid_gap_reg;
                out_sat_reg <= skid_sat_reg;
            end
        end
        else if (vld_r_reg)
        begin
            if (out_vld_reg && !out_take)
            begin
                skid_gap_reg <= gap_clip;
                skid_sat_reg <= sat;
            end
            else
            begin
                out_gap_reg <= gap_clip;
                out_sat_reg <= sat;
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign edge_gap      = out_gap_reg;
    assign gap_saturated = out_sat_reg;

endmodule

FILE: sim/dce_checker.sv
`timescale 1ns / 1ps

module dce_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [dce_pkg::COORD_W-1:0] a_pos_x,
    input  logic signed [dce_pkg::COORD_W-1:0] a_pos_y,
    input  logic [dce_pkg::RADIUS_W-1:0]       a_lobe_radius,
    input  logic [dce_pkg::AXIS_W-1:0]         a_axis_len,
    input  logic [dce_pkg::ANGLE_W-1:0]        a_angle,
    input  logic signed [dce_pkg::COORD_W-1:0] b_pos_x,
    input  logic signed [dce_pkg::COORD_W-1:0] b_pos_y,
    input  logic [dce_pkg::RADIUS_W-1:0]       b_lobe_radius,
    input  logic [dce_pkg::AXIS_W-1:0]         b_axis_len,
    input  logic [dce_pkg::ANGLE_W-1:0]        b_angle,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [31:0]                 edge_gap,
    input  logic                               gap_saturated,
    output int                                 fail_count,
    output int                                 gaps_pending,
    output int                                 gaps_checked
);

    localparam int ABITS = dce_pkg::ANGLE_BITS_DEF;

    typedef struct {
        logic signed [31:0] gap;
        logic               sat;
    } gap_result_t;

    gap_result_t expected_gaps[$];
    int          saturated_seen;

    function automatic longint unsigned quarter_wave(longint unsigned p);
        longint unsigned divisors[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t, d;
        x  = (p * longint'(dce_pkg::HALF_PI_Q30) + (64'd1 << (ABITS - 3))) >> (ABITS - 2);
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = dce_pkg::ONE_Q30;
        for (int i = 0; i < 6; i++)
        begin
            d = ((x2 * t) >> 30) / divisors[i];
            t = (d > dce_pkg::ONE_Q30) ? 64'd0 : dce_pkg::ONE_Q30 - d;
        end
        t = (x * t + (64'd1 << 29)) >> 30;
        return (t > dce_pkg::ONE_Q30) ? longint'(dce_pkg::ONE_Q30) : t;
    endfunction

    function automatic longint sine_q30(longint unsigned idx);
        longint unsigned quarter, quad, p, s;
        quarter = 64'd1 << (ABITS - 2);
        idx     = idx & ((64'd1 << ABITS) - 1);
        quad    = idx >> (ABITS - 2);
        p       = idx & (quarter - 1);
        s       = quad[0] ? quarter_wave(quarter - p) : quarter_wave(p);
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Round half away from zero on a right shift by 31.
    function automatic longint scale_offset(longint v);
        longint half;
        half = longint'(1) << 30;
        if (v < 0)
            return -(((-v) + half) >>> 31);
        return (v + half) >>> 31;
    endfunction

    function automatic void lobe_offsets(input logic [dce_pkg::RADIUS_W-1:0] r,
                                         input logic [dce_pkg::AXIS_W-1:0] len,
                                         input logic [dce_pkg::ANGLE_W-1:0] ang,
                                         output longint ox, output longint oy);
        longint          twice_m;
        longint unsigned idx;
        twice_m = longint'(len) - 2 * longint'(r);
        idx     = ang >> (16 - ABITS);
        ox      = scale_offset(twice_m * sine_q30(idx + (64'd1 << (ABITS - 2))));
        oy      = scale_offset(twice_m * sine_q30(idx));
    endfunction

    function automatic longint unsigned squared_span(longint dx, longint dy);
        longint          lim;
        longint unsigned ux, uy, sx, sy;
        lim = longint'(1) << 32;
        if (dx <= -lim || dx >= lim || dy <= -lim || dy >= lim)
            return '1;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        sx = ux * ux;
        sy = uy * uy;
        return (sx > ~sy) ? '1 : sx + sy;
    endfunction

    function automatic longint unsigned nearest_root(longint unsigned v);
        longint unsigned root, bits, rem;
        root = 0;
        bits = 64'd1 << 62;
        rem  = v;
        while (bits > rem)
            bits = bits >> 2;
        while (bits != 0)
        begin
            if (rem >= root + bits)
            begin
                rem  = rem - (root + bits);
                root = (root >> 1) + bits;
            end
            else
                root = root >> 1;
            bits = bits >> 2;
        end
        return (v - root * root > root) ? root + 1 : root;
    endfunction

    function automatic gap_result_t predict_gap();
        gap_result_t     res;
        longint          aox, aoy, box, boy, gap;
        longint          alx[2], aly[2], blx[2], bly[2];
        longint unsigned closest, d;
        lobe_offsets(a_lobe_radius, a_axis_len, a_angle, aox, aoy);
        lobe_offsets(b_lobe_radius, b_axis_len, b_angle, box, boy);
        alx[0] = longint'(a_pos_x) + aox;  aly[0] = longint'(a_pos_y) + aoy;
        alx[1] = longint'(a_pos_x) - aox;  aly[1] = longint'(a_pos_y) - aoy;
        blx[0] = longint'(b_pos_x) + box;  bly[0] = longint'(b_pos_y) + boy;
        blx[1] = longint'(b_pos_x) - box;  bly[1] = longint'(b_pos_y) - boy;
        closest = '1;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
            begin
                d = squared_span(alx[i] - blx[j], aly[i] - bly[j]);
                if (d < closest)
                    closest = d;
            end
        gap = longint'(nearest_root(closest)) - longint'(a_lobe_radius)
              - longint'(b_lobe_radius);
        res.sat = 1'b0;
        if (gap > 64'sd2147483647)
        begin
            gap     = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (gap < -64'sd2147483648)
        begin
            gap     = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.gap = gap[31:0];
        return res;
    endfunction

    assign gaps_pending = expected_gaps.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_gaps.delete();
            fail_count     <= 0;
            gaps_checked   <= 0;
            saturated_seen <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_gaps.push_back(predict_gap());
            if (out_valid && !out_stall)
            begin
                if (expected_gaps.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result gap=%0d sat=%0b",
                                 $time, edge_gap, gap_saturated);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    gap_result_t want;
                    want = expected_gaps.pop_front();
                    if (want.gap !== edge_gap || want.sat !== gap_saturated)
                    begin
                        if (fail_count < 10)
                            $display("%0t: gap mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     $time, want.gap, want.sat, edge_gap, gap_saturated);
                        fail_count <= fail_count + 1;
                    end
                    if (gap_saturated === 1'b1)
                        saturated_seen <= saturated_seen + 1;
                end
                gaps_checked <= gaps_checked + 1;
            end
        end
    end

endmodule

FILE: sim/tb_dumbbell_cell_edge_distance_top.sv
`timescale 1ns / 1ps

module tb_dumbbell_cell_edge_distance_top;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [dce_pkg::COORD_W-1:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
    logic [dce_pkg::RADIUS_W-1:0]       a_lobe_radius, b_lobe_radius;
    logic [dce_pkg::AXIS_W-1:0]         a_axis_len, b_axis_len;
    logic [dce_pkg::ANGLE_W-1:0]        a_angle, b_angle;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [31:0]                 edge_gap;
    logic                               gap_saturated;
    int                                 fail_count, gaps_pending, gaps_checked;

    dumbbell_cell_edge_distance_top DUT (.*);

    dce_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly short, now and then long.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pair(input logic [31:0] ax, ay, input logic [23:0] ar,
                             input logic [24:0] al, input logic [15:0] aa,
                             input logic [31:0] bx, by, input logic [23:0] br,
                             input logic [24:0] bl, input logic [15:0] ba,
                             input bit allow_gap);
        int idle;
        idle = allow_gap ? gap_cycles() : 0;
        if (idle > 0)
        begin
            in_valid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        a_pos_x = ax;  a_pos_y = ay;  a_lobe_radius = ar;  a_axis_len = al;  a_angle = aa;
        b_pos_x = bx;  b_pos_y = by;  b_lobe_radius = br;  b_axis_len = bl;  b_angle = ba;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // A plausible pair of cells near each other, with an occasional short axis.
    task automatic send_plausible_pair(input bit allow_gap);
        logic [31:0] base_x, base_y;
        logic [23:0] ar, br;
        logic [24:0] al, bl;
        base_x = $urandom;
        base_y = $urandom;
        ar = 24'($urandom_range(0, 1 << 20));
        br = 24'($urandom_range(0, 1 << 20));
        al = ($urandom_range(0, 9) == 0) ? 25'($urandom_range(0, 2 * ar))
                                          : 25'(2 * ar + $urandom_range(0, 1 << 21));
        bl = ($urandom_range(0, 9) == 0) ? 25'($urandom_range(0, 2 * br))
                                          : 25'(2 * br + $urandom_range(0, 1 << 21));
        send_pair(base_x, base_y, ar, al, 16'($urandom),
                  base_x + 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22),
                  base_y + 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22),
                  br, bl, 16'($urandom), allow_gap);
    endtask

    initial
    begin
        int stall_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                stall_len = gap_cycles();
                out_stall = (stall_len > 0);
                repeat (stall_len) @(negedge clk);
                out_stall = 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(20, 80)) @(negedge clk);
        end
    end

    initial
    begin
        logic [15:0] angles[6];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_pos_x, a_pos_y, a_lobe_radius, a_axis_len, a_angle} = '0;
        {b_pos_x, b_pos_y, b_lobe_radius, b_axis_len, b_angle} = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zeros, full-scale fields, each quadrant of the angle table.
        send_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, '1, '1, '1,
                  32'h80000000, 32'h80000000, '1, '1, '1, 1'b0);
        send_pair(32'h80000000, 32'h7FFFFFFF, '1, '1, 16'h4000,
                  32'h80000000, 32'h7FFFFFFF, '1, '1, 16'hC000, 1'b0);
        foreach (angles[i])
            send_pair(32'h0001_0000, 32'hFFFF_0000, 24'h01_0000, 25'h08_0000, angles[i],
                      32'h0009_0000, 32'h0002_0000, 24'h00_8000, 25'h03_0000,
                      angles[5 - i], 1'b0);
        // Short axis: lobes swap sides.
        send_pair('0, '0, 24'hFF_FFFF, 25'h0, 16'h1234,
                  32'h0100_0000, '0, 24'h10_0000, 25'h00_0001, 16'h9876, 1'b0);
        // Huge separation: gap clips high.
        send_pair(32'h8000_0000, 32'h8000_0000, '0, '0, '0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);
        send_pair(32'h8000_0000, '0, '0, '0, '0, 32'h7FFF_FFFF, '0, '0, '0, '0, 1'b0);
        // Deep overlap: identical cells give a strongly negative gap.
        send_pair(32'h1234_5678, 32'hF00D_0000, 24'hFF_FFFF, 25'h1FF_FFFE, 16'h7777,
                  32'h1234_5678, 32'hF00D_0000, 24'hFF_FFFF, 25'h1FF_FFFE, 16'h7777, 1'b0);
        send_pair(32'h0000_0001, '0, 24'h1, 25'h2, 16'h0001,
                  32'hFFFF_FFFF, '0, 24'h1, 25'h4, 16'hFFFE, 1'b0);

        for (int n = 0; n < 1200; n++)
        begin
            if ($urandom_range(0, 99) < 70)
                send_plausible_pair(n % 200 > 30);
            else
                send_pair($urandom, $urandom, 24'($urandom), 25'($urandom), 16'($urandom),
                          $urandom, $urandom, 24'($urandom), 25'($urandom), 16'($urandom),
                          n % 200 > 30);
        end
        in_valid = 1'b0;

        wait (gaps_pending == 0);
        repeat (200) @(negedge clk);
        $display("Covered %0d cell pairs: directed extremes, every angle quadrant,",
                 gaps_checked);
        $display("short axes, clipped far separations and overlaps, under random stalls.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // The timeout also has to cover the sine table build after reset.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", gaps_pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
